// File: design/itsl_pkg.sv
package itsl_pkg;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_LOWER = 2'd1,
        CLS_UPPER = 2'd2,
        CLS_DIGIT = 2'd3
    } cls_t;

    localparam int MAX_RES = 4;
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [7:0] SEP_RESET   = 8'h2D;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] HIGH_START  = 8'h80;
    localparam logic [7:0] DIGIT_LO    = 8'h30;
    localparam logic [7:0] DIGIT_HI    = 8'h39;
    localparam logic [7:0] UPPER_LO    = 8'h41;
    localparam logic [7:0] UPPER_HI    = 8'h5A;
    localparam logic [7:0] LOWER_LO    = 8'h61;
    localparam logic [7:0] LOWER_HI    = 8'h7A;
    localparam logic [1:0] RUN_MAX     = 2'd3;

    typedef struct packed {
        logic [7:0] chr;
        logic       valid;
        logic       last;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] ent;
        logic [CNT_W-1:0]   cnt;
    } res_group_t;

    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        c = CLS_OTHER;
        if (b >= HIGH_START)
            c = CLS_OTHER;
        else if (b >= DIGIT_LO && b <= DIGIT_HI)
            c = CLS_DIGIT;
        else if (b >= UPPER_LO && b <= UPPER_HI)
            c = CLS_UPPER;
        else if (b >= LOWER_LO && b <= LOWER_HI)
            c = CLS_LOWER;
        return c;
    endfunction

    // Appends one character beat to the group.
    function automatic res_group_t push(input res_group_t g, input logic [7:0] ch);
        res_group_t r;
        r = g;
        r.ent[g.cnt[IDX_W-1:0]].chr   = ch;
        r.ent[g.cnt[IDX_W-1:0]].valid = 1'b1;
        r.ent[g.cnt[IDX_W-1:0]].last  = 1'b0;
        r.cnt = g.cnt + CNT_W'(1);
        return r;
    endfunction

endpackage

// File: design/itsl_if.sv
interface itsl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface itsl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    output ready);
endinterface

// File: design/itsl_conv.sv
module itsl_conv (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic [7:0]            separator,
    output itsl_pkg::res_group_t  grp
);
    import itsl_pkg::*;

    cls_t       prev_class_reg, prev_class_next;
    logic       word_seen_reg, word_seen_next;
    logic [7:0] held_char_reg, held_char_next;
    logic       held_valid_reg, held_valid_next;
    logic [1:0] upper_run_len_reg, upper_run_len_next;

    cls_t       c;
    res_group_t g;

    always_comb
    begin
        c                  = classify(in_byte);
        g                  = '0;
        prev_class_next    = c;
        word_seen_next     = word_seen_reg;
        held_char_next     = held_char_reg;
        held_valid_next    = held_valid_reg;
        upper_run_len_next = upper_run_len_reg;

        case (c)
            CLS_UPPER:
            begin
                if (held_valid_reg)
                    g = push(g, held_char_reg);
                if (prev_class_reg == CLS_UPPER)
                begin
                    if (upper_run_len_reg != RUN_MAX)
                        upper_run_len_next = upper_run_len_reg + 2'd1;
                end
                else
                begin
                    if (word_seen_reg)
                        g = push(g, separator);
                    word_seen_next     = 1'b1;
                    upper_run_len_next = 2'd1;
                end
                held_char_next  = in_byte + CASE_OFFSET;
                held_valid_next = 1'b1;
            end
            CLS_LOWER, CLS_DIGIT:
            begin
                if (prev_class_reg == CLS_UPPER)
                begin
                    // A long capital run hands its last letter to the new word.
                    if (c == CLS_LOWER && upper_run_len_reg == RUN_MAX && held_valid_reg)
                        g = push(g, separator);
                    if (held_valid_reg)
                        g = push(g, held_char_reg);
                end
                else
                begin
                    if (held_valid_reg)
                        g = push(g, held_char_reg);
                    if (prev_class_reg == CLS_OTHER
                        || (prev_class_reg == CLS_DIGIT && c == CLS_LOWER))
                    begin
                        if (word_seen_reg)
                            g = push(g, separator);
                        word_seen_next = 1'b1;
                    end
                end
                held_valid_next    = 1'b0;
                held_char_next     = '0;
                g                  = push(g, in_byte);
                upper_run_len_next = '0;
            end
            default:
            begin
                if (held_valid_reg)
                    g = push(g, held_char_reg);
                held_valid_next    = 1'b0;
                held_char_next     = '0;
                upper_run_len_next = '0;
            end
        endcase

        if (in_last)
        begin
            if (held_valid_next)
                g = push(g, held_char_next);
            if (g.cnt == '0)
                g.cnt = CNT_W'(1);
            g.ent[IDX_W'(g.cnt - CNT_W'(1))].last = 1'b1;
            prev_class_next    = CLS_OTHER;
            word_seen_next     = 1'b0;
            held_char_next     = '0;
            held_valid_next    = 1'b0;
            upper_run_len_next = '0;
        end
    end

    assign grp = g;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_class_reg    <= CLS_OTHER;
            word_seen_reg     <= 1'b0;
            held_char_reg     <= '0;
            held_valid_reg    <= 1'b0;
            upper_run_len_reg <= '0;
        end
        else if (load)
        begin
            prev_class_reg    <= prev_class_next;
            word_seen_reg     <= word_seen_next;
            held_char_reg     <= held_char_next;
            held_valid_reg    <= held_valid_next;
            upper_run_len_reg <= upper_run_len_next;
        end
    end

    a_held_after_upper: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> prev_class_reg == CLS_UPPER)
        else $error("held letter without a preceding capital");

    // A dropped byte may give no beat at all, but a final byte always gives one.
    a_group_size: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> grp.cnt < CNT_W'(MAX_RES) && (grp.cnt != '0 || !in_last))
        else $error("result group size out of range");

    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        load && in_last |=> prev_class_reg == CLS_OTHER && !word_seen_reg
                            && !held_valid_reg && upper_run_len_reg == '0)
        else $error("stream state not cleared after final byte");

endmodule

// File: design/itsl_obuf.sv
module itsl_obuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  itsl_pkg::res_group_t  grp,
    output logic                  can_load,
    itsl_out_if.source            out_ch
);
    import itsl_pkg::*;

    res_t [MAX_RES-1:0] ent_reg, ent_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pop;

    assign pop      = out_ch.valid && out_ch.ready;
    // The group is reloaded whole, so it may enter only when the buffer is empty or as its last beat leaves.
    assign can_load = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && out_ch.ready);

    always_comb
    begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            ent_next = grp.ent;
            cnt_next = grp.cnt;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
                ent_next[i] = ent_reg[i+1];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign out_ch.valid     = (cnt_reg != '0);
    assign out_ch.out_byte  = ent_reg[0].chr;
    assign out_ch.out_valid = ent_reg[0].valid;
    assign out_ch.out_last  = ent_reg[0].last;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result group loaded over pending beats");

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.out_valid |-> out_ch.out_last)
        else $error("end marker beat without last flag");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RES))
        else $error("result buffer count overflow");

endmodule

// File: design/identifier_to_separated_lower.sv
// Data path: a byte accepted on in_ch is registered in the input stage, converted
// combinationally and loaded into the result buffer, which presents its result beats.
// Throughput: one byte per cycle while each byte gives at most one beat and out_ch is not
// stalled; a byte that gives more beats holds the input while the result buffer drains them.
// Reset (rst_n, asynchronous, active low) empties both stages, clears word state
// and sets the separator to a hyphen.
module identifier_to_separated_lower (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    itsl_in_if.sink     in_ch,
    itsl_out_if.source  out_ch
);
    import itsl_pkg::*;

    logic [7:0] separator_reg;
    logic       ivalid_reg;
    logic [7:0] ibyte_reg;
    logic       ilast_reg;

    logic       can_load;
    logic       load;
    res_group_t grp;

    assign load        = ivalid_reg && can_load;
    assign in_ch.ready = !ivalid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEP_RESET;
            ivalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                separator_reg <= cfg_wdata;
            if (in_ch.ready)
                ivalid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            ibyte_reg <= in_ch.in_byte;
            ilast_reg <= in_ch.in_last;
        end
    end

    itsl_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .in_byte   (ibyte_reg),
        .in_last   (ilast_reg),
        .separator (separator_reg),
        .grp       (grp)
    );

    itsl_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .grp      (grp),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

// File: bench/itsl_checker.sv
`timescale 1ns / 1ps

module itsl_checker
    import itsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    itsl_in_if         in_ch,
    itsl_out_if        out_ch,
    output int         fail_count,
    output int         pending,
    output int         beats_seen
);

    // Own copy of the converter state and the separator register.
    logic [7:0] join_char;
    cls_t       prev_kind;
    logic       word_open;
    logic [7:0] held_letter;
    logic       held_ok;
    logic [1:0] caps_run;

    res_t expected_chars[$];
    int   item_beats;

    function automatic cls_t kind_of(input logic [7:0] b);
        if (b inside {[DIGIT_LO:DIGIT_HI]})
            return CLS_DIGIT;
        if (b inside {[UPPER_LO:UPPER_HI]})
            return CLS_UPPER;
        if (b inside {[LOWER_LO:LOWER_HI]})
            return CLS_LOWER;
        return CLS_OTHER;
    endfunction

    function void emit_char(input logic [7:0] ch);
        res_t r;
        r.chr   = ch;
        r.valid = 1'b1;
        r.last  = 1'b0;
        expected_chars.push_back(r);
        item_beats++;
    endfunction

    function void clear_word_state();
        prev_kind   = CLS_OTHER;
        word_open   = 1'b0;
        held_letter = 8'h00;
        held_ok     = 1'b0;
        caps_run    = 2'd0;
    endfunction

    // Works out the beats that one input byte causes and queues them.
    function void lower_and_split(input logic [7:0] b, input logic lst);
        cls_t k;
        res_t marker;
        k = kind_of(b);
        item_beats = 0;
        if (k == CLS_UPPER) begin
            if (held_ok)
                emit_char(held_letter);
            if (prev_kind != CLS_UPPER) begin
                if (word_open)
                    emit_char(join_char);
                word_open = 1'b1;
                caps_run  = 2'd1;
            end
            else if (caps_run != RUN_MAX) begin
                caps_run = caps_run + 2'd1;
            end
            held_letter = b + CASE_OFFSET;
            held_ok     = 1'b1;
        end
        else if (k == CLS_LOWER || k == CLS_DIGIT) begin
            if (prev_kind == CLS_UPPER) begin
                // A long capital run hands its last letter to the word that follows.
                if (k == CLS_LOWER && caps_run == RUN_MAX && held_ok)
                    emit_char(join_char);
                if (held_ok)
                    emit_char(held_letter);
            end
            else begin
                if (held_ok)
                    emit_char(held_letter);
                if (prev_kind == CLS_OTHER || (prev_kind == CLS_DIGIT && k == CLS_LOWER)) begin
                    if (word_open)
                        emit_char(join_char);
                    word_open = 1'b1;
                end
            end
            held_ok     = 1'b0;
            held_letter = 8'h00;
            emit_char(b);
            caps_run = 2'd0;
        end
        else begin
            if (held_ok)
                emit_char(held_letter);
            held_ok     = 1'b0;
            held_letter = 8'h00;
            caps_run    = 2'd0;
        end
        prev_kind = k;

        if (lst) begin
            if (held_ok)
                emit_char(held_letter);
            if (item_beats == 0) begin
                marker.chr   = 8'h00;
                marker.valid = 1'b0;
                marker.last  = 1'b1;
                expected_chars.push_back(marker);
            end
            else begin
                expected_chars[expected_chars.size() - 1].last = 1'b1;
            end
            clear_word_state();
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            join_char = SEP_RESET;
            clear_word_state();
            expected_chars.delete();
            pending <= 0;
        end
        else begin
            if (cfg_we)
                join_char = cfg_wdata;

            if (out_ch.valid && out_ch.ready) begin
                beats_seen <= beats_seen + 1;
                if (expected_chars.size() == 0) begin
                    $error("unexpected output beat: out_byte %02h out_valid %0b out_last %0b",
                           out_ch.out_byte, out_ch.out_valid, out_ch.out_last);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_chars.pop_front();
                    if (out_ch.out_byte !== want.chr || out_ch.out_valid !== want.valid ||
                        out_ch.out_last !== want.last) begin
                        fail_count <= fail_count + 1;
                        if (out_ch.out_byte !== want.chr)
                            $error("out_byte: expected %02h, got %02h",
                                   want.chr, out_ch.out_byte);
                        if (out_ch.out_valid !== want.valid)
                            $error("out_valid: expected %0b, got %0b",
                                   want.valid, out_ch.out_valid);
                        if (out_ch.out_last !== want.last)
                            $error("out_last: expected %0b, got %0b",
                                   want.last, out_ch.out_last);
                    end
                end
            end

            if (in_ch.valid && in_ch.ready)
                lower_and_split(in_ch.in_byte, in_ch.in_last);

            pending <= expected_chars.size();
        end
    end

endmodule

// File: bench/tb_identifier_to_separated_lower.sv
`timescale 1ns / 1ps

module tb_identifier_to_separated_lower;
    import itsl_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 120;
    localparam int PHASE_BYTES = 48;
    localparam int DRAIN_WAIT  = 6;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    itsl_in_if  in_if ();
    itsl_out_if out_if ();

    int fail_count;
    int pending;
    int beats_seen;

    // Driver-side controls read by the receiver process.
    logic hold_req;
    logic quiet;

    int bytes_sent;
    int idents_sent;
    int seps_written;

    identifier_to_separated_lower i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    itsl_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_ch      (in_if),
        .out_ch     (out_if),
        .fail_count (fail_count),
        .pending    (pending),
        .beats_seen (beats_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int g;
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        in_if.in_last <= lst;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        bytes_sent++;
        if (lst)
            idents_sent++;
        g = quiet ? 0 : gap_len();
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Builds an identifier from word-like pieces, with some punctuation and junk bytes.
    task automatic send_ident();
        logic [7:0] text[$];
        int         pieces;
        int         pick;
        int         len;
        pieces = $urandom_range(1, 4);
        for (int p = 0; p < pieces; p++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                text.push_back(UPPER_LO + 8'($urandom_range(0, 25)));
                len = $urandom_range(1, 5);
                repeat (len) text.push_back(LOWER_LO + 8'($urandom_range(0, 25)));
            end
            else if (pick < 40) begin
                len = $urandom_range(2, 5);
                repeat (len) text.push_back(UPPER_LO + 8'($urandom_range(0, 25)));
            end
            else if (pick < 60) begin
                len = $urandom_range(1, 6);
                repeat (len) text.push_back(LOWER_LO + 8'($urandom_range(0, 25)));
            end
            else if (pick < 72) begin
                len = $urandom_range(1, 3);
                repeat (len) text.push_back(DIGIT_LO + 8'($urandom_range(0, 9)));
            end
            else if (pick < 82) begin
                case ($urandom_range(0, 3))
                    0: text.push_back(8'h5F);
                    1: text.push_back(8'h2D);
                    2: text.push_back(8'h20);
                    default: text.push_back(8'h2E);
                endcase
            end
            else begin
                len = $urandom_range(1, 2);
                repeat (len) text.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (int i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1);
    endtask

    // Lets every expected beat arrive, then waits out the bytes that give none.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seps_written++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int  hold_left;
        int  run_left;
        int  stall_left;
        bit  hold_done;
        hold_left  = 0;
        run_left   = 0;
        stall_left = 0;
        hold_done  = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end
            else if (quiet) begin
                out_if.ready <= 1'b1;
            end
            else if (run_left > 0) begin
                out_if.ready <= 1'b1;
                run_left--;
            end
            else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end
            else begin
                run_left   = $urandom_range(0, 99) < 15 ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 4);
                stall_left = gap_len();
                out_if.ready <= 1'b1;
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout after %0d cycles without a beat", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic [7:0] sep_list [6];
        logic [7:0] sep;
        int         phase_start;
        sep_list = '{8'h5F, 8'h00, 8'hFF, 8'h41, 8'h37, 8'h2D};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'h00;
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.in_last = 1'b0;
        hold_req      = 1'b0;
        quiet         = 1'b0;
        bytes_sent    = 0;
        idents_sent   = 0;
        seps_written  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed identifiers with the separator at its reset value.
        send_str("xY2z");
        send_str("ABCd");
        send_byte(8'h00, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(HIGH_START, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h39, 1'b1);
        send_str("ABCDe");

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            sep = (ph == 5) ? 8'($urandom_range(0, 255)) : sep_list[ph];
            write_separator(sep);
            hold_req <= (ph == 1);
            quiet    <= (ph == 3);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_ident();
        end

        quiet <= 1'b0;
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes in %0d identifiers and checked %0d result beats.",
                 bytes_sent, idents_sent, beats_seen);
        $display("Separator ran at its reset value and %0d written values, 0x00 and 0xFF among them.",
                 seps_written);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
